[rtl/vcsc_pkg.sv]
`timescale 1ns / 1ps

package vcsc_pkg;

  localparam int NUM_PRODUCTS = 10;

  localparam int CMD_W      = 3;
  localparam int COIN_W     = 2;
  localparam int PID_W      = 4;
  localparam int COUNT_W    = 7;
  localparam int STATUS_W   = 3;
  localparam int CREDIT_W   = 16;
  localparam int PRICE_W    = 12;
  localparam int TAKINGS_W  = 24;
  localparam int MASK_W     = 10;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;

  localparam int PROD_IDX_W = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
  localparam int MASK_N     = (NUM_PRODUCTS < MASK_W) ? NUM_PRODUCTS : MASK_W;

  localparam logic [COUNT_W-1:0]   THRESHOLD_RESET = 7'd3;
  localparam logic [COUNT_W-1:0]   CAPACITY_RESET  = 7'd99;
  localparam logic [TAKINGS_W-1:0] FLOAT_RESET     = 24'd20000;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FLOAT     = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_COIN    = 3'd0,
    CMD_BUY     = 3'd1,
    CMD_CHANGE  = 3'd2,
    CMD_RESTOCK = 3'd3,
    CMD_FREE    = 3'd4,
    CMD_COLLECT = 3'd5,
    CMD_RESET   = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_SHORT       = 3'd1,
    ST_SOLD_OUT    = 3'd2,
    ST_BAD_PRODUCT = 3'd3,
    ST_BAD_COUNT   = 3'd4,
    ST_NO_CHANGE   = 3'd5,
    ST_SATURATED   = 3'd6
  } status_t;

  typedef struct packed {
    logic capture;
    logic execute;
  } ctrl_t;

  function automatic logic [COUNT_W-1:0] coin_value(input logic [COIN_W-1:0] code);
    logic [COUNT_W-1:0] v;
    case (code)
      2'd0:    v = 7'd10;
      2'd1:    v = 7'd20;
      2'd2:    v = 7'd50;
      default: v = 7'd100;
    endcase
    return v;
  endfunction

  function automatic logic [COUNT_W-1:0] init_stock(input logic [PID_W-1:0] i);
    logic [COUNT_W-1:0] v;
    case (i)
      4'd0:    v = 7'd7;
      4'd1:    v = 7'd8;
      4'd2:    v = 7'd9;
      4'd3:    v = 7'd10;
      4'd4:    v = 7'd0;
      4'd5:    v = 7'd2;
      4'd6:    v = 7'd8;
      4'd7:    v = 7'd9;
      4'd8:    v = 7'd1;
      4'd9:    v = 7'd3;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

  function automatic logic [PRICE_W-1:0] init_price(input logic [PID_W-1:0] i);
    logic [PRICE_W-1:0] v;
    case (i)
      4'd0:    v = 12'd50;
      4'd1:    v = 12'd100;
      4'd2:    v = 12'd70;
      4'd3:    v = 12'd70;
      4'd4:    v = 12'd120;
      4'd5:    v = 12'd130;
      4'd6:    v = 12'd220;
      4'd7:    v = 12'd150;
      4'd8:    v = 12'd150;
      4'd9:    v = 12'd300;
      default: v = 12'd0;
    endcase
    return v;
  endfunction

endpackage

[rtl/vcsc_ctrl.sv]
`timescale 1ns / 1ps

module vcsc_ctrl
  import vcsc_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_stall,
  output logic  out_valid,
  input  logic  out_stall,
  output ctrl_t ctrl
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;
  logic   out_valid_next;
  logic   accept;

  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign accept   = in_valid && !in_stall;

  assign ctrl.capture = accept;
  assign ctrl.execute = (state == S_EXEC);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == S_EXEC)
    else $error("accepted transaction did not start execution");

  a_exec_result: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |=> out_valid)
    else $error("execution did not present a result");

  a_exec_slot_free: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC |-> !out_valid)
    else $error("result register still occupied during execution");

  a_rose_after_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_EXEC))
    else $error("result appeared without execution");

endmodule

[rtl/vcsc_datapath.sv]
`timescale 1ns / 1ps

module vcsc_datapath
  import vcsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  ctrl_t                 ctrl,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [COIN_W-1:0]     coin_code,
  input  logic [PID_W-1:0]      product_id,
  input  logic [COUNT_W-1:0]    add_count,
  output logic [STATUS_W-1:0]   status,
  output logic                  dispensed,
  output logic [CREDIT_W-1:0]   credit_cents,
  output logic [CREDIT_W-1:0]   change_cents,
  output logic [PRICE_W-1:0]    shortfall_cents,
  output logic [TAKINGS_W-1:0]  collected_cents,
  output logic [TAKINGS_W-1:0]  takings_cents,
  output logic [COUNT_W-1:0]    stock_left,
  output logic [MASK_W-1:0]     low_stock_mask
);

  logic [COUNT_W-1:0]   threshold;
  logic [COUNT_W-1:0]   capacity;
  logic [TAKINGS_W-1:0] float_value;

  logic [CMD_W-1:0]     cmd_q;
  logic [COIN_W-1:0]    coin_q;
  logic [PID_W-1:0]     pid_q;
  logic [COUNT_W-1:0]   add_q;

  logic [CREDIT_W-1:0]  credit, credit_next;
  logic [TAKINGS_W-1:0] takings, takings_next;
  logic [COUNT_W-1:0]   stock [NUM_PRODUCTS];
  logic [COUNT_W-1:0]   stock_next [NUM_PRODUCTS];

  logic [PROD_IDX_W-1:0] idx;
  logic                  pid_ok;
  logic [COUNT_W-1:0]    cur;
  logic [PRICE_W-1:0]    price;
  logic [CREDIT_W:0]     coin_sum;
  logic [TAKINGS_W:0]    sale_sum;
  logic [COUNT_W:0]      restock_sum;

  status_t               st;
  logic                  disp;
  logic [CREDIT_W-1:0]   change;
  logic [PRICE_W-1:0]    shortfall;
  logic [TAKINGS_W-1:0]  collected;
  logic [COUNT_W-1:0]    left;
  logic [MASK_W-1:0]     mask;

  assign idx    = pid_q[PROD_IDX_W-1:0];
  assign pid_ok = {1'b0, pid_q} < (PID_W + 1)'(NUM_PRODUCTS);
  assign cur    = pid_ok ? stock[idx] : '0;
  assign price  = init_price(pid_q);

  assign coin_sum    = {1'b0, credit} + (CREDIT_W + 1)'(coin_value(coin_q));
  assign sale_sum    = {1'b0, takings} + (TAKINGS_W + 1)'(price);
  assign restock_sum = {1'b0, cur} + {1'b0, add_q};

  always_comb begin
    credit_next  = credit;
    takings_next = takings;
    stock_next   = stock;
    st           = ST_OK;
    disp         = 1'b0;
    change       = '0;
    shortfall    = '0;
    collected    = '0;
    case (cmd_t'(cmd_q))
      CMD_COIN: begin
        if (coin_sum[CREDIT_W]) begin
          credit_next = '1;
          st          = ST_SATURATED;
        end else begin
          credit_next = coin_sum[CREDIT_W-1:0];
        end
      end
      CMD_BUY: begin
        if (!pid_ok) begin
          st = ST_BAD_PRODUCT;
        end else if ({4'b0, price} > credit) begin
          st        = ST_SHORT;
          shortfall = price - credit[PRICE_W-1:0];
        end else if (cur == '0) begin
          st = ST_SOLD_OUT;
        end else begin
          credit_next = credit - {4'b0, price};
          if (sale_sum[TAKINGS_W]) begin
            takings_next = '1;
            st           = ST_SATURATED;
          end else begin
            takings_next = sale_sum[TAKINGS_W-1:0];
          end
          stock_next[idx] = cur - 7'd1;
          disp            = 1'b1;
        end
      end
      CMD_CHANGE: begin
        if (credit != '0) begin
          change      = credit;
          credit_next = '0;
        end else begin
          st = ST_NO_CHANGE;
        end
      end
      CMD_RESTOCK: begin
        if (!pid_ok) begin
          st = ST_BAD_PRODUCT;
        end else if (add_q == '0 || restock_sum > {1'b0, capacity}) begin
          st = ST_BAD_COUNT;
        end else begin
          stock_next[idx] = restock_sum[COUNT_W-1:0];
        end
      end
      CMD_FREE: begin
        if (!pid_ok) begin
          st = ST_BAD_PRODUCT;
        end else if (cur == '0) begin
          st = ST_SOLD_OUT;
        end else begin
          stock_next[idx] = cur - 7'd1;
          disp            = 1'b1;
        end
      end
      CMD_COLLECT: begin
        collected    = takings;
        takings_next = float_value;
      end
      CMD_RESET: begin
        credit_next  = '0;
        takings_next = float_value;
        for (int i = 0; i < NUM_PRODUCTS; i++) begin
          stock_next[i] = init_stock(PID_W'(i));
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    mask = '0;
    for (int i = 0; i < MASK_N; i++) begin
      mask[i] = stock_next[i] < threshold;
    end
    left = pid_ok ? stock_next[idx] : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold   <= THRESHOLD_RESET;
      capacity    <= CAPACITY_RESET;
      float_value <= FLOAT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_THRESHOLD: threshold   <= cfg_data[COUNT_W-1:0];
        CFG_CAPACITY:  capacity    <= cfg_data[COUNT_W-1:0];
        CFG_FLOAT:     float_value <= cfg_data[TAKINGS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      credit  <= '0;
      takings <= FLOAT_RESET;
      for (int i = 0; i < NUM_PRODUCTS; i++) begin
        stock[i] <= init_stock(PID_W'(i));
      end
    end else if (ctrl.execute) begin
      credit  <= credit_next;
      takings <= takings_next;
      stock   <= stock_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      cmd_q  <= cmd;
      coin_q <= coin_code;
      pid_q  <= product_id;
      add_q  <= add_count;
    end
    if (ctrl.execute) begin
      status          <= st;
      dispensed       <= disp;
      credit_cents    <= credit_next;
      change_cents    <= change;
      shortfall_cents <= shortfall;
      collected_cents <= collected;
      takings_cents   <= takings_next;
      stock_left      <= left;
      low_stock_mask  <= mask;
    end
  end

endmodule

[rtl/vending_credit_and_stock_controller_core.sv]
`timescale 1ns / 1ps

// Vending credit and stock controller, all amounts in integer cents. Each input
// transaction carries one command (coin, buy, change, restock, free vend, collect,
// reset) and yields exactly one result transaction with status, credit, takings,
// the addressed product's stock and the live low-stock mask. Each command is
// first registered, then the execute state does the read-modify-write of the
// stock table and money registers; no new command is taken while one executes.
// A new command is taken only when the result register is empty or is being
// read in the same cycle, so a result held by out_stall stalls the input.
// Configuration writes on cfg_we/cfg_index/cfg_data are meant for idle periods only.
module vending_credit_and_stock_controller_core
  import vcsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [COIN_W-1:0]     coin_code,
  input  logic [PID_W-1:0]      product_id,
  input  logic [COUNT_W-1:0]    add_count,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   status,
  output logic                  dispensed,
  output logic [CREDIT_W-1:0]   credit_cents,
  output logic [CREDIT_W-1:0]   change_cents,
  output logic [PRICE_W-1:0]    shortfall_cents,
  output logic [TAKINGS_W-1:0]  collected_cents,
  output logic [TAKINGS_W-1:0]  takings_cents,
  output logic [COUNT_W-1:0]    stock_left,
  output logic [MASK_W-1:0]     low_stock_mask
);

  ctrl_t ctrl;

  vcsc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctrl      (ctrl)
  );

  vcsc_datapath u_datapath (
    .clk             (clk),
    .rst             (rst),
    .ctrl            (ctrl),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .cmd             (cmd),
    .coin_code       (coin_code),
    .product_id      (product_id),
    .add_count       (add_count),
    .status          (status),
    .dispensed       (dispensed),
    .credit_cents    (credit_cents),
    .change_cents    (change_cents),
    .shortfall_cents (shortfall_cents),
    .collected_cents (collected_cents),
    .takings_cents   (takings_cents),
    .stock_left      (stock_left),
    .low_stock_mask  (low_stock_mask)
  );

endmodule

[bench/vend_checker.sv]
`timescale 1ns / 1ps

module vend_checker
  import vcsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  logic [CMD_W-1:0]      cmd,
  input  logic [COIN_W-1:0]     coin_code,
  input  logic [PID_W-1:0]      product_id,
  input  logic [COUNT_W-1:0]    add_count,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  logic [STATUS_W-1:0]   status,
  input  logic                  dispensed,
  input  logic [CREDIT_W-1:0]   credit_cents,
  input  logic [CREDIT_W-1:0]   change_cents,
  input  logic [PRICE_W-1:0]    shortfall_cents,
  input  logic [TAKINGS_W-1:0]  collected_cents,
  input  logic [TAKINGS_W-1:0]  takings_cents,
  input  logic [COUNT_W-1:0]    stock_left,
  input  logic [MASK_W-1:0]     low_stock_mask,
  output int unsigned           fail_count,
  output int unsigned           pending
);

  localparam logic [16*COUNT_W-1:0] START_STOCK = {
    7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd3, 7'd1,
    7'd9, 7'd8, 7'd2, 7'd0, 7'd10, 7'd9, 7'd8, 7'd7
  };
  localparam logic [16*PRICE_W-1:0] SHELF_PRICE = {
    12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd0, 12'd300, 12'd150,
    12'd150, 12'd220, 12'd130, 12'd120, 12'd70, 12'd70, 12'd100, 12'd50
  };
  localparam logic [4*COUNT_W-1:0] COIN_CENTS = {7'd100, 7'd50, 7'd20, 7'd10};
  localparam int unsigned CREDIT_CAP  = 65535;
  localparam int unsigned TAKINGS_CAP = 16777215;

  typedef struct {
    status_t               status;
    logic                  dispensed;
    logic [CREDIT_W-1:0]   credit;
    logic [CREDIT_W-1:0]   change;
    logic [PRICE_W-1:0]    shortfall;
    logic [TAKINGS_W-1:0]  collected;
    logic [TAKINGS_W-1:0]  takings;
    logic [COUNT_W-1:0]    stock;
    logic [MASK_W-1:0]     mask;
  } receipt_t;

  logic [COUNT_W-1:0]   thresh_cfg;
  logic [COUNT_W-1:0]   capacity_cfg;
  logic [TAKINGS_W-1:0] float_cfg;
  logic [CREDIT_W-1:0]  credit_now;
  logic [TAKINGS_W-1:0] takings_now;
  logic [COUNT_W-1:0]   shelf [NUM_PRODUCTS];
  receipt_t             due_receipts [$];

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t: %s got %0d expected %0d", $time, what, got, want);
    fail_count++;
  endtask

  task automatic refill_machine();
    credit_now = '0;
    takings_now = float_cfg;
    for (int i = 0; i < NUM_PRODUCTS; i++)
      shelf[i] = (i < 16) ? START_STOCK[i*COUNT_W +: COUNT_W] : '0;
  endtask

  task automatic vend_outcome(input logic [CMD_W-1:0] op, input logic [COIN_W-1:0] coin,
                              input logic [PID_W-1:0] pid, input logic [COUNT_W-1:0] add,
                              output receipt_t r);
    logic        known;
    int unsigned sum;
    int unsigned price;
    int unsigned level;
    known = pid < NUM_PRODUCTS;
    price = 32'(SHELF_PRICE[pid*PRICE_W +: PRICE_W]);
    if (known) level = 32'(shelf[pid]);
    else level = 0;
    r.status = ST_OK;
    r.dispensed = 1'b0;
    r.change = '0;
    r.shortfall = '0;
    r.collected = '0;
    case (op)
      CMD_COIN: begin
        sum = 32'(credit_now) + 32'(COIN_CENTS[coin*COUNT_W +: COUNT_W]);
        if (sum > CREDIT_CAP) begin
          sum = CREDIT_CAP;
          r.status = ST_SATURATED;
        end
        credit_now = CREDIT_W'(sum);
      end
      CMD_BUY: begin
        if (!known) begin
          r.status = ST_BAD_PRODUCT;
        end else if (32'(credit_now) < price) begin
          r.status = ST_SHORT;
          r.shortfall = PRICE_W'(price - 32'(credit_now));
        end else if (level == 0) begin
          r.status = ST_SOLD_OUT;
        end else begin
          credit_now = CREDIT_W'(32'(credit_now) - price);
          sum = 32'(takings_now) + price;
          if (sum > TAKINGS_CAP) begin
            sum = TAKINGS_CAP;
            r.status = ST_SATURATED;
          end
          takings_now = TAKINGS_W'(sum);
          shelf[pid] = COUNT_W'(level - 1);
          r.dispensed = 1'b1;
        end
      end
      CMD_CHANGE: begin
        if (credit_now != 0) begin
          r.change = credit_now;
          credit_now = '0;
        end else begin
          r.status = ST_NO_CHANGE;
        end
      end
      CMD_RESTOCK: begin
        if (!known) r.status = ST_BAD_PRODUCT;
        else if (add == 0 || level + 32'(add) > 32'(capacity_cfg)) r.status = ST_BAD_COUNT;
        else shelf[pid] = COUNT_W'(level + 32'(add));
      end
      CMD_FREE: begin
        if (!known) begin
          r.status = ST_BAD_PRODUCT;
        end else if (level == 0) begin
          r.status = ST_SOLD_OUT;
        end else begin
          shelf[pid] = COUNT_W'(level - 1);
          r.dispensed = 1'b1;
        end
      end
      CMD_COLLECT: begin
        r.collected = takings_now;
        takings_now = float_cfg;
      end
      CMD_RESET: refill_machine();
      default: ;
    endcase
    r.credit = credit_now;
    r.takings = takings_now;
    if (known) r.stock = shelf[pid];
    else r.stock = '0;
    r.mask = '0;
    for (int i = 0; i < NUM_PRODUCTS && i < MASK_W; i++)
      if (shelf[i] < thresh_cfg) r.mask[i] = 1'b1;
  endtask

  always @(posedge clk) begin : watch
    receipt_t want;
    receipt_t fresh;
    if (rst) begin
      thresh_cfg = THRESHOLD_RESET;
      capacity_cfg = CAPACITY_RESET;
      float_cfg = FLOAT_RESET;
      refill_machine();
      due_receipts.delete();
      pending <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_THRESHOLD) thresh_cfg = cfg_data[COUNT_W-1:0];
        else if (cfg_index == CFG_CAPACITY) capacity_cfg = cfg_data[COUNT_W-1:0];
        else if (cfg_index == CFG_FLOAT) float_cfg = cfg_data[TAKINGS_W-1:0];
      end
      if (out_valid && !out_stall) begin
        if (due_receipts.size() == 0) begin
          report_mismatch("results beyond those due", 1, 0);
        end else begin
          want = due_receipts.pop_front();
          if (status !== want.status) report_mismatch("status", status, want.status);
          if (dispensed !== want.dispensed)
            report_mismatch("dispensed", dispensed, want.dispensed);
          if (credit_cents !== want.credit)
            report_mismatch("credit_cents", credit_cents, want.credit);
          if (change_cents !== want.change)
            report_mismatch("change_cents", change_cents, want.change);
          if (shortfall_cents !== want.shortfall)
            report_mismatch("shortfall_cents", shortfall_cents, want.shortfall);
          if (collected_cents !== want.collected)
            report_mismatch("collected_cents", collected_cents, want.collected);
          if (takings_cents !== want.takings)
            report_mismatch("takings_cents", takings_cents, want.takings);
          if (stock_left !== want.stock)
            report_mismatch("stock_left", stock_left, want.stock);
          if (low_stock_mask !== want.mask)
            report_mismatch("low_stock_mask", low_stock_mask, want.mask);
        end
      end
      if (in_valid && !in_stall) begin
        vend_outcome(cmd, coin_code, product_id, add_count, fresh);
        due_receipts.push_back(fresh);
      end
      pending <= due_receipts.size();
    end
  end

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;
  import vcsc_pkg::*;

  localparam logic [CMD_W-1:0]     CMD_SPARE     = 3'd7;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;
  localparam logic [TAKINGS_W-1:0] TAKINGS_TOP   = 24'hFFFFFF;
  localparam int unsigned          CYCLE_LIMIT   = 200000;
  localparam int unsigned          SETTLE_CYCLES = 16;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd = '0;
  logic [COIN_W-1:0]     coin_code = '0;
  logic [PID_W-1:0]      product_id = '0;
  logic [COUNT_W-1:0]    add_count = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic                  dispensed;
  logic [CREDIT_W-1:0]   credit_cents;
  logic [CREDIT_W-1:0]   change_cents;
  logic [PRICE_W-1:0]    shortfall_cents;
  logic [TAKINGS_W-1:0]  collected_cents;
  logic [TAKINGS_W-1:0]  takings_cents;
  logic [COUNT_W-1:0]    stock_left;
  logic [MASK_W-1:0]     low_stock_mask;
  int unsigned           fail_count;
  int unsigned           pending;
  int unsigned           cycles = 0;
  bit                    steady = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  vending_credit_and_stock_controller_core i_dut (.*);

  vend_checker i_checker (.*);

  always @(negedge clk) out_stall <= !steady && ($urandom_range(99) < 36);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic push_command(input logic [CMD_W-1:0] op, input logic [COIN_W-1:0] coin,
                              input logic [PID_W-1:0] pid, input logic [COUNT_W-1:0] add);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    cmd <= op;
    coin_code <= coin;
    product_id <= pid;
    add_count <= add;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic retune(input logic [COUNT_W-1:0] threshold, input logic [COUNT_W-1:0] capacity,
                        input logic [TAKINGS_W-1:0] float_val);
    drain();
    write_reg(CFG_THRESHOLD, CFG_DATA_W'(threshold));
    write_reg(CFG_CAPACITY, CFG_DATA_W'(capacity));
    write_reg(CFG_FLOAT, CFG_DATA_W'(float_val));
  endtask

  task automatic send_random(input bit keep_credit, input int unsigned coin_share);
    logic [CMD_W-1:0]   op;
    logic [PID_W-1:0]   pid;
    logic [COUNT_W-1:0] add;
    int unsigned        pick;
    pick = $urandom_range(99);
    if (pick < 34) op = CMD_COIN;
    else if (pick < 58) op = CMD_BUY;
    else if (pick < 66) op = CMD_CHANGE;
    else if (pick < 76) op = CMD_RESTOCK;
    else if (pick < 84) op = CMD_FREE;
    else if (pick < 89) op = CMD_COLLECT;
    else if (pick < 92) op = CMD_RESET;
    else if (pick < 95) op = CMD_SPARE;
    else op = CMD_W'($urandom_range(7));
    // hold the credit while it climbs to the ceiling
    if (keep_credit && (op == CMD_CHANGE || op == CMD_RESET)) op = CMD_BUY;
    pid = ($urandom_range(99) < 85) ? PID_W'($urandom_range(NUM_PRODUCTS - 1))
                                    : PID_W'($urandom_range(15));
    pick = $urandom_range(99);
    add = (pick < 8) ? '0 : (pick < 80) ? COUNT_W'($urandom_range(12, 1))
                                        : COUNT_W'($urandom_range(127));
    if ($urandom_range(99) < coin_share) push_command(CMD_COIN, 2'd3, pid, add);
    else push_command(op, COIN_W'($urandom_range(3)), pid, add);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    push_command(CMD_CHANGE, 2'd0, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd4, 7'd0);
    push_command(CMD_COIN, 2'd0, 4'd0, 7'd0);
    push_command(CMD_COIN, 2'd1, 4'd0, 7'd0);
    push_command(CMD_COIN, 2'd2, 4'd0, 7'd0);
    push_command(CMD_COIN, 2'd3, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd4, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd12, 7'd0);
    push_command(CMD_FREE, 2'd0, 4'd15, 7'd0);
    push_command(CMD_RESTOCK, 2'd0, 4'd10, 7'd5);
    push_command(CMD_RESTOCK, 2'd0, 4'd0, 7'd0);
    push_command(CMD_RESTOCK, 2'd0, 4'd0, 7'd127);
    push_command(CMD_RESTOCK, 2'd0, 4'd0, 7'd93);
    push_command(CMD_FREE, 2'd0, 4'd8, 7'd0);
    push_command(CMD_FREE, 2'd0, 4'd8, 7'd0);
    push_command(CMD_CHANGE, 2'd0, 4'd0, 7'd0);
    push_command(CMD_COLLECT, 2'd0, 4'd0, 7'd0);
    push_command(CMD_SPARE, 2'd3, 4'd15, 7'd127);
    push_command(CMD_RESET, 2'd0, 4'd0, 7'd0);

    retune(7'd99, 7'd127, TAKINGS_TOP - 24'd50);
    push_command(CMD_COLLECT, 2'd0, 4'd0, 7'd0);
    push_command(CMD_COIN, 2'd3, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd0, 7'd0);
    push_command(CMD_BUY, 2'd0, 4'd0, 7'd0);

    drain();
    write_reg(CFG_SPARE, CFG_DATA_W'($urandom));

    retune(THRESHOLD_RESET, CAPACITY_RESET, FLOAT_RESET);
    for (int n = 0; n < 300; n++) begin
      if (n == 150) drain();
      send_random(1'b0, 0);
    end

    retune(7'd0, 7'd1, 24'd0);
    steady = 1'b1;
    repeat (220) send_random(1'b0, 0);
    steady = 1'b0;

    retune(7'd99, 7'd127, TAKINGS_TOP);
    repeat (220) send_random(1'b0, 0);

    retune(COUNT_W'($urandom_range(99)), COUNT_W'($urandom_range(127, 1)),
           TAKINGS_W'($urandom_range(TAKINGS_TOP)));
    repeat (760) send_random(1'b1, 97);

    retune(COUNT_W'($urandom_range(99)), COUNT_W'($urandom_range(127, 1)),
           TAKINGS_W'($urandom_range(TAKINGS_TOP)));
    repeat (250) send_random(1'b0, 0);

    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("tb OK");
    else $display("tb NOT OK");
    $finish;
  end

endmodule
